// ===== rtl/ctrc_pkg.sv =====
// Shared types, codes and keyword tables for the command tag row count block.
package ctrc_pkg;

  localparam int KW_COUNT = 8;
  // Keywords below this index are select-type; the rest are DML.
  localparam int KW_SELECT_COUNT = 3;
  localparam int VALUE_W = 64;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Keyword text, NUL padded to eight columns.
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"S", "E", "L", "E", "C", "T", CH_NUL, CH_NUL},
    '{"F", "E", "T", "C", "H", CH_NUL, CH_NUL, CH_NUL},
    '{"M", "O", "V", "E", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"I", "N", "S", "E", "R", "T", CH_NUL, CH_NUL},
    '{"U", "P", "D", "A", "T", "E", CH_NUL, CH_NUL},
    '{"D", "E", "L", "E", "T", "E", CH_NUL, CH_NUL},
    '{"C", "O", "P", "Y", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"M", "E", "R", "G", "E", CH_NUL, CH_NUL, CH_NUL}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd6, 3'd5, 3'd4, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5
  };

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_WORD = 2'd1,
    PH_NUM  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_SELECT = 2'd1,
    CLS_DML    = 2'd2
  } word_class_e;

  typedef enum logic [2:0] {
    NUM_START   = 3'd0,
    NUM_SIGN    = 3'd1,
    NUM_DIGITS  = 3'd2,
    NUM_NULSTOP = 3'd3,
    NUM_BAD     = 3'd4
  } num_status_e;

  typedef struct packed {
    phase_e               phase;
    logic [KW_COUNT-1:0]  hits;
    logic [2:0]           pos;
    word_class_e          cls;
    num_status_e          status;
    logic                 neg;
    logic                 ovf;
    logic [VALUE_W-1:0]   value;
  } tag_state_t;

  localparam tag_state_t STATE_RESET = '{
    phase:  PH_LEAD,
    hits:   '1,
    pos:    '0,
    cls:    CLS_OTHER,
    status: NUM_START,
    neg:    1'b0,
    ovf:    1'b0,
    value:  '0
  };

  // Tag summary handed from the scanner to the result stage.
  typedef struct packed {
    logic               known;
    logic               sel;
    logic               num_ok;
    logic               neg;
    logic [VALUE_W-1:0] value;
  } tag_snap_t;

endpackage

// ===== rtl/command_tag_row_count.sv =====
// Top level: input register, tag scanner and result register.
// A tag's last byte passes through the input register, the scanner snapshot and the result register to the outputs.
// Throughput: one byte per cycle while in_stall_o is low; one result per tag, formed from the scanner snapshot.
// The input, snapshot and result registers each hold while the next stage stalls.
// Reset (rst_ni low, asynchronous) empties all stages and returns the scanner to
// the leading-trim state.
module command_tag_row_count
  import ctrc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         tag_byte_i,
  input  logic               byte_present_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VALUE_W-1:0] row_count_o,
  output logic               select_type_o
);

  logic               in_valid_q;
  logic [7:0]         tag_byte_q;
  logic               present_q, last_q;
  logic               item_take, snap_valid, out_adv;
  tag_snap_t          snap;
  logic               out_valid_q;
  logic [VALUE_W-1:0] row_count_q, row_count_d;
  logic               select_type_q;

  assign in_stall_o = in_valid_q && !item_take;
  assign out_adv = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= snap_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      tag_byte_q <= tag_byte_i;
      present_q <= byte_present_i;
      last_q <= last_byte_i;
    end
  end

  ctrc_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (in_valid_q),
    .tag_byte_i     (tag_byte_q),
    .byte_present_i (present_q),
    .last_byte_i    (last_q),
    .item_take_o    (item_take),
    .snap_take_i    (out_adv),
    .snap_valid_o   (snap_valid),
    .snap_o         (snap)
  );

  // Apply the sign modulo 2^64; unknown tags and malformed counts give zero.
  always_comb begin
    if (snap.known && snap.num_ok) begin
      row_count_d = snap.neg ? (~snap.value + {{(VALUE_W-1){1'b0}}, 1'b1}) : snap.value;
    end else begin
      row_count_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && snap_valid) begin
      row_count_q <= row_count_d;
      select_type_q <= snap.known && snap.sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_count_o = row_count_q;
  assign select_type_o = select_type_q;

endmodule

// ===== rtl/ctrc_scan.sv =====
// Per-byte tag scanner: keyword match, count parse and trailing-trim commit.
module ctrc_scan
  import ctrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  logic [7:0] tag_byte_i,
  input  logic       byte_present_i,
  input  logic       last_byte_i,
  output logic       item_take_o,
  input  logic       snap_take_i,
  output logic       snap_valid_o,
  output tag_snap_t  snap_o
);

  tag_state_t live_q, live_d, upd;
  tag_state_t commit_q, commit_d, commit_nx;
  logic       kept_q, kept_d, kept_nx;
  logic       snap_valid_q, snap_valid_d;
  tag_snap_t  snap_q, snap_d;

  logic       is_ws, is_digit, kept_now, snap_ready, tag_end;
  logic [VALUE_W-1:0] digit_val;
  logic [VALUE_W+3:0] acc;

  assign is_ws = (tag_byte_i == CH_SPACE) || (tag_byte_i >= CH_TAB && tag_byte_i <= CH_CR);
  assign is_digit = (tag_byte_i >= CH_ZERO) && (tag_byte_i <= CH_NINE);
  assign digit_val = {{(VALUE_W-8){1'b0}}, tag_byte_i - CH_ZERO};
  // value * 10 + digit; the top nibble flags overflow
  assign acc = ({4'b0, live_q.value} << 3) + ({4'b0, live_q.value} << 1)
             + {4'b0, digit_val};

  assign snap_ready = !snap_valid_q || snap_take_i;
  assign item_take_o = item_valid_i && (!last_byte_i || snap_ready);
  assign tag_end = item_take_o && last_byte_i;

  always_comb begin
    upd = live_q;
    kept_now = 1'b0;
    if (byte_present_i) begin
      if (!(live_q.phase == PH_LEAD && is_ws)) begin
        if (live_q.phase != PH_NUM) begin
          if (tag_byte_i == CH_SPACE) begin
            upd.cls = CLS_OTHER;
            for (int k = 0; k < KW_COUNT; k++) begin
              if (live_q.hits[k] && KW_LEN[k] == live_q.pos) begin
                upd.cls = (k < KW_SELECT_COUNT) ? CLS_SELECT : CLS_DML;
              end
            end
            upd.phase = PH_NUM;
            upd.status = NUM_START;
            upd.neg = 1'b0;
            upd.ovf = 1'b0;
            upd.value = '0;
          end else begin
            upd.phase = PH_WORD;
            for (int k = 0; k < KW_COUNT; k++) begin
              if (live_q.pos >= KW_LEN[k] || KW_TEXT[k][live_q.pos] != tag_byte_i) begin
                upd.hits[k] = 1'b0;
              end
            end
            if (live_q.pos != 3'd7) begin
              upd.pos = live_q.pos + 3'd1;
            end
          end
        end else if (tag_byte_i == CH_SPACE) begin
          // a new last word starts
          upd.status = NUM_START;
          upd.neg = 1'b0;
          upd.ovf = 1'b0;
          upd.value = '0;
        end else begin
          unique case (live_q.status)
            NUM_START: begin
              if (tag_byte_i == CH_PLUS) begin
                upd.status = NUM_SIGN;
              end else if (tag_byte_i == CH_MINUS) begin
                upd.status = NUM_SIGN;
                upd.neg = 1'b1;
              end else if (is_digit) begin
                upd.status = NUM_DIGITS;
                upd.value = digit_val;
              end else if (!(tag_byte_i >= CH_TAB && tag_byte_i <= CH_CR)) begin
                upd.status = NUM_BAD;
              end
            end
            NUM_SIGN: begin
              if (is_digit) begin
                upd.status = NUM_DIGITS;
                upd.value = digit_val;
              end else begin
                upd.status = NUM_BAD;
              end
            end
            NUM_DIGITS: begin
              if (is_digit) begin
                if (live_q.ovf || acc[VALUE_W+3:VALUE_W] != 4'd0) begin
                  upd.ovf = 1'b1;
                  upd.value = '1;
                end else begin
                  upd.value = acc[VALUE_W-1:0];
                end
              end else if (tag_byte_i == CH_NUL) begin
                upd.status = NUM_NULSTOP;
              end else begin
                upd.status = NUM_BAD;
              end
            end
            default: ;
          endcase
        end
      end
      kept_now = (tag_byte_i != CH_NUL) && !is_ws;
    end

    commit_nx = kept_now ? upd : commit_q;
    kept_nx = kept_q || kept_now;

    snap_d.known = kept_nx && commit_nx.phase == PH_NUM && commit_nx.cls != CLS_OTHER;
    snap_d.sel = commit_nx.cls == CLS_SELECT;
    snap_d.num_ok = commit_nx.status == NUM_DIGITS || commit_nx.status == NUM_NULSTOP;
    snap_d.neg = commit_nx.neg && !commit_nx.ovf;
    snap_d.value = commit_nx.value;

    live_d = live_q;
    commit_d = commit_q;
    kept_d = kept_q;
    if (tag_end) begin
      // restart for the next tag
      live_d = STATE_RESET;
      commit_d = STATE_RESET;
      kept_d = 1'b0;
    end else if (item_take_o) begin
      live_d = upd;
      commit_d = commit_nx;
      kept_d = kept_nx;
    end

    if (tag_end) begin
      snap_valid_d = 1'b1;
    end else if (snap_take_i) begin
      snap_valid_d = 1'b0;
    end else begin
      snap_valid_d = snap_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= STATE_RESET;
      commit_q <= STATE_RESET;
      kept_q <= 1'b0;
      snap_valid_q <= 1'b0;
    end else begin
      live_q <= live_d;
      commit_q <= commit_d;
      kept_q <= kept_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_end) begin
      snap_q <= snap_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o = snap_q;

endmodule
